// ----- design/knap_pkg.sv -----
`default_nettype none
package knap_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int MAX_K = 16;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(MAX_K + 1);
  localparam int CW = 31;
  localparam int DW = 63;
  localparam int NQW = 5;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_DEACT = 2'd2;
  localparam logic [1:0] OP_ACT = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SAME = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic valid;
    logic [DW-1:0] distance;
    logic [IDX_W-1:0] idx;
  } cand_t;
endpackage
`default_nettype wire

// ----- design/k_nearest_active_points.sv -----
`default_nettype none
// Channel | Dir | tdata (low bit up)                                   | tuser
// in_     | in  | coord_x[30:0] coord_y[61:31] point_index[71:62]     | operation[1:0]
//         |     | neighbor_count[76:72], zero fill to 80               |
// out_    | out | result_index[9:0] squared_distance[72:10], fill 80   | status[2:0], tlast
// A load, activate or deactivate answers with a single status beat; output stalls hold it.
// A query scans the point RAM through the distance pipeline, drains that pipeline, then
// sends one result per cycle unless the output stalls; the cell chain holds the sorted list.
// Reset is synchronous and clears the point count; stored points are not cleared.
// A stalled output holds the block; input is taken only while idle.
module k_nearest_active_points (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [79:0] in_tdata,  // coord_x, coord_y, point_index, neighbor_count
  input  wire logic [1:0]  in_tuser,  // operation
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [79:0] out_tdata, // result_index, squared_distance
  output      logic [2:0]  out_tuser, // status
  output      logic        out_tlast
);
  import knap_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_MARK = 3'd1, S_SCAN = 3'd2,
                         S_DRAIN = 3'd3, S_EMIT = 3'd4, S_ONE = 3'd5;
  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] loaded_r, scan_r;
  logic [1:0] op_r;
  logic [CW-1:0] ox_r, oy_r;
  logic [IDX_W:0] pidx_r;
  logic [KW-1:0] k_r, sent_r;
  logic [2:0] drain_r;
  logic [IDX_W-1:0] oidx_r;
  logic [2:0] ost_r;
  logic mark_valid;
  logic [CW-1:0] rx, ry;
  logic ract, rv_r;
  logic [IDX_W-1:0] ridx_r;
  logic accept;
  logic [CW-1:0] in_x, in_y;
  logic [NQW-1:0] in_k;
  logic [IDX_W-1:0] in_pi;
  logic we_xy, we_a, a_wd;
  logic [IDX_W-1:0] a_ra;
  logic [IDX_W-1:0] wa;
  cand_t cand;
  cand_t held [MAX_K];
  cand_t prevs [MAX_K];
  logic takes [MAX_K];
  logic ptake [MAX_K];
  logic shift, clear;
  logic emit_last;

  assign in_x = in_tdata[CW-1:0];
  assign in_y = in_tdata[2*CW-1:CW];
  assign in_pi = in_tdata[2*CW+IDX_W-1:2*CW];
  assign in_k = in_tdata[2*CW+IDX_W+NQW-1:2*CW+IDX_W];
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  assign we_xy = accept && in_tuser == OP_LOAD && loaded_r < CNT_W'(MAX_POINTS);
  assign wa = we_xy ? loaded_r[IDX_W-1:0] : pidx_r[IDX_W-1:0];
  assign we_a = we_xy || (state_r == S_MARK && mark_valid && ract != op_r[0]);
  assign a_wd = we_xy ? 1'b1 : op_r[0];
  assign a_ra = (state_r == S_SCAN) ? scan_r[IDX_W-1:0] : in_pi;

  knap_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_x (.clk(clk), .we(we_xy),
    .waddr(loaded_r[IDX_W-1:0]), .wdata(in_x), .raddr(scan_r[IDX_W-1:0]), .rdata(rx));
  knap_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y (.clk(clk), .we(we_xy),
    .waddr(loaded_r[IDX_W-1:0]), .wdata(in_y), .raddr(scan_r[IDX_W-1:0]), .rdata(ry));
  knap_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_a (.clk(clk), .we(we_a),
    .waddr(wa), .wdata(a_wd), .raddr(a_ra), .rdata(ract));

  assign mark_valid = pidx_r < loaded_r;

  knap_dist u_dist (.clk(clk), .rst_n(rst_n), .in_v(rv_r && ract), .in_idx(ridx_r),
    .px(rx), .py(ry), .ox(ox_r), .oy(oy_r), .cand(cand));

  assign shift = (state_r == S_EMIT) && out_tready;
  assign clear = accept;

  genvar g;
  generate
    for (g = 0; g < MAX_K; g++) begin : g_cell
      if (g == 0) begin : g_h
        assign prevs[g] = cand;
        assign ptake[g] = 1'b0;
      end else begin : g_n
        assign prevs[g] = held[g-1];
        assign ptake[g] = takes[g-1];
      end
      knap_cell u_cell (.clk(clk), .rst_n(rst_n), .clear(clear),
        .enable(g < k_r), .shift(1'b0), .cand(cand),
        .prev(prevs[g]), .prev_takes(ptake[g]), .takes(takes[g]), .held(held[g]));
    end
  endgenerate

  logic [$clog2(MAX_K)-1:0] osel;
  assign osel = sent_r[$clog2(MAX_K)-1:0];
  assign emit_last = (sent_r + 1'b1 == k_r) || !held[osel+1'b1].valid || (&osel);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        case (in_tuser)
          OP_QUERY: state_nxt = (in_k == '0) ? S_ONE : S_SCAN;
          OP_LOAD: state_nxt = S_ONE;
          default: state_nxt = S_MARK;
        endcase
      end
      S_MARK: state_nxt = S_ONE;
      S_SCAN: if (scan_r >= loaded_r) state_nxt = S_DRAIN;
      S_DRAIN: if (drain_r == 3'd5) state_nxt = held[0].valid ? S_EMIT : S_ONE;
      S_EMIT: if (out_tready && emit_last) state_nxt = S_IDLE;
      S_ONE: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loaded_r <= '0;
      rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r <= (state_r == S_SCAN) && scan_r < loaded_r;
      if (we_xy) loaded_r <= loaded_r + 1'b1;
    end
    ridx_r <= scan_r[IDX_W-1:0];
    if (state_r == S_SCAN) scan_r <= scan_r + 1'b1;
    if (state_r == S_DRAIN) drain_r <= drain_r + 1'b1;
    if (shift) sent_r <= sent_r + 1'b1;
    if (accept) begin
      op_r <= in_tuser;
      ox_r <= in_x;
      oy_r <= in_y;
      pidx_r <= {1'b0, in_pi};
      k_r <= (in_k > NQW'(MAX_K)) ? KW'(MAX_K) : KW'(in_k);
      scan_r <= '0;
      drain_r <= '0;
      sent_r <= '0;
      case (in_tuser)
        OP_LOAD: begin
          oidx_r <= we_xy ? loaded_r[IDX_W-1:0] : '0;
          ost_r <= we_xy ? ST_OK : ST_FULL;
        end
        OP_QUERY: begin
          oidx_r <= '0;
          ost_r <= ST_NONE;
        end
        default: begin
          oidx_r <= in_pi;
          ost_r <= ST_NOT_FOUND;
        end
      endcase
    end
    if (state_r == S_MARK && mark_valid) ost_r <= (ract == op_r[0]) ? ST_SAME : ST_OK;
  end

  assign out_tvalid = (state_r == S_EMIT) || (state_r == S_ONE);
  assign out_tuser = (state_r == S_EMIT) ? ST_OK : ost_r;
  assign out_tlast = (state_r == S_ONE) || ((state_r == S_EMIT) && emit_last);
  always_comb begin
    out_tdata = '0;
    if (state_r == S_EMIT) begin
      out_tdata[IDX_W-1:0] = held[osel].idx;
      out_tdata[IDX_W+DW-1:IDX_W] = held[osel].distance;
    end else begin
      out_tdata[IDX_W-1:0] = oidx_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) accept |=> !in_tready);
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_POINTS)) else $error("point count overflow");
endmodule
`default_nettype wire

// ----- design/knap_ram.sv -----
`default_nettype none
module knap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/knap_cell.sv -----
`default_nettype none
module knap_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic          enable,
  input  wire logic          shift,
  input  wire knap_pkg::cand_t cand,
  input  wire knap_pkg::cand_t prev,
  input  wire logic          prev_takes,
  output      logic          takes,
  output      knap_pkg::cand_t held
);
  import knap_pkg::*;
  cand_t held_r, held_nxt;
  always_comb begin
    takes = cand.valid && (!held_r.valid || cand.distance < held_r.distance);
    held_nxt = held_r;
    if (shift) begin
      held_nxt = prev;
    end else if (enable && takes) begin
      held_nxt = prev_takes ? prev : cand;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      held_r.valid <= 1'b0;
    end else begin
      held_r.valid <= held_nxt.valid;
    end
    held_r.distance <= held_nxt.distance;
    held_r.idx <= held_nxt.idx;
  end
  assign held = held_r;
endmodule
`default_nettype wire

// ----- design/knap_dist.sv -----
`default_nettype none
module knap_dist (
  input  wire logic                    clk,
  input  wire logic                    in_v,
  input  wire logic [knap_pkg::IDX_W-1:0] in_idx,
  input  wire logic [knap_pkg::CW-1:0] px,
  input  wire logic [knap_pkg::CW-1:0] py,
  input  wire logic [knap_pkg::CW-1:0] ox,
  input  wire logic [knap_pkg::CW-1:0] oy,
  input  wire logic                    rst_n,
  output      knap_pkg::cand_t         cand
);
  import knap_pkg::*;
  logic [CW:0] ax_r, ay_r;
  logic [2*CW+1:0] sx_r, sy_r;
  logic v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] i1_r, i2_r, i3_r;
  logic [DW-1:0] d3_r;
  logic signed [CW:0] dx, dy;
  always_comb begin
    dx = $signed({px[CW-1], px}) - $signed({ox[CW-1], ox});
    dy = $signed({py[CW-1], py}) - $signed({oy[CW-1], oy});
  end
  always_ff @(posedge clk) begin
    ax_r <= dx[CW] ? -dx : dx;
    ay_r <= dy[CW] ? -dy : dy;
    sx_r <= ax_r * ax_r;
    sy_r <= ay_r * ay_r;
    d3_r <= DW'(sx_r + sy_r);
    i1_r <= in_idx;
    i2_r <= i1_r;
    i3_r <= i2_r;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end
  assign cand = '{valid: v3_r, distance: d3_r, idx: i3_r};
endmodule
`default_nettype wire

// ----- tb/tb_k_nearest_active_points.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_k_nearest_active_points;
  import knap_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [DW-1:0]    distance;
    logic [2:0]       status;
    logic             last;
  } point_result_t;

  class knn_scoreboard;
    logic [CW-1:0] px[MAX_POINTS];
    logic [CW-1:0] py[MAX_POINTS];
    bit            active[MAX_POINTS];
    int            loaded;
    point_result_t pending[$];
    int            mismatches;

    function void clear();
      loaded = 0;
      mismatches = 0;
      pending.delete();
    endfunction

    function logic [DW-1:0] dist_sq(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                                    int i);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [127:0]       s;
      dx = 64'(signed'(px[i])) - 64'(ox);
      dy = 64'(signed'(py[i])) - 64'(oy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      s = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      return s[DW-1:0];
    endfunction

    function void push(logic [IDX_W-1:0] i, logic [DW-1:0] d, logic [2:0] st, bit l);
      point_result_t r;
      r.index = i;
      r.distance = d;
      r.status = st;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void set_mark(logic [IDX_W-1:0] i, bit want);
      if (i >= loaded) push(i, '0, ST_NOT_FOUND, 1);
      else if (active[i] == want) push(i, '0, ST_SAME, 1);
      else begin
        active[i] = want;
        push(i, '0, ST_OK, 1);
      end
    endfunction

    function void note_input(logic [1:0] op, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [IDX_W-1:0] pi, logic [NQW-1:0] nk);
      logic [DW-1:0] bd[MAX_K];
      int            bi[MAX_K];
      int            k;
      int            n;
      int            pos;
      logic [DW-1:0] d;
      case (op)
        OP_LOAD: begin
          if (loaded >= MAX_POINTS) push('0, '0, ST_FULL, 1);
          else begin
            px[loaded] = x;
            py[loaded] = y;
            active[loaded] = 1;
            push(loaded[IDX_W-1:0], '0, ST_OK, 1);
            loaded++;
          end
        end
        OP_DEACT: set_mark(pi, 0);
        OP_ACT: set_mark(pi, 1);
        default: begin
          if (nk == 0) push('0, '0, ST_NONE, 1);
          else begin
            k = (nk > MAX_K) ? MAX_K : nk;
            n = 0;
            for (int i = 0; i < loaded; i++) begin
              if (active[i]) begin
                d = dist_sq(x, y, i);
                pos = -1;
                if (n < k) begin
                  pos = n;
                  n++;
                end else if (d < bd[k-1]) pos = k - 1;
                if (pos >= 0) begin
                  while (pos > 0 && bd[pos-1] > d) begin
                    bd[pos] = bd[pos-1];
                    bi[pos] = bi[pos-1];
                    pos--;
                  end
                  bd[pos] = d;
                  bi[pos] = i;
                end
              end
            end
            if (n == 0) push('0, '0, ST_NONE, 1);
            for (int i = 0; i < n; i++) push(bi[i][IDX_W-1:0], bd[i], ST_OK, i == n - 1);
          end
        end
      endcase
    endfunction

    function void check_result(point_result_t got);
      point_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_LOAD;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  knn_scoreboard board;
  bit            calm = 0;
  int            quiet_cycles = 0;
  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  k_nearest_active_points i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always @(posedge clk) begin
    point_result_t r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        r.index = out_tdata[IDX_W-1:0];
        r.distance = out_tdata[IDX_W+DW-1:IDX_W];
        r.status = out_tuser;
        r.last = out_tlast;
        board.check_result(r);
      end
      out_tready <= calm || ($urandom_range(99) >= 10);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
        $display("tb_k_nearest_active_points: FAIL");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, logic [CW-1:0] x, logic [CW-1:0] y,
                      logic [IDX_W-1:0] pi, logic [NQW-1:0] nk);
    while (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {3'b0, nk, pi, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(op, x, y, pi, nk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return 31'h3FFF_FFFF;
      1: return 31'h4000_0000;
      2: return CW'($urandom_range(200)) - 31'd100;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(OP_QUERY, '0, '0, '0, 5'd4);
    send(OP_DEACT, '0, '0, 10'd0, '0);
    send(OP_LOAD, 31'h3FFF_FFFF, 31'h3FFF_FFFF, 10'h3FF, 5'd31);
    send(OP_LOAD, 31'h4000_0000, 31'h4000_0000, '0, '0);
    send(OP_LOAD, '0, '0, '0, '0);
    send(OP_LOAD, '0, '0, '0, '0);
    send(OP_QUERY, 31'h4000_0000, 31'h4000_0000, '0, 5'd31);
    send(OP_QUERY, 31'h3FFF_FFFF, 31'h4000_0000, '0, 5'd2);
    send(OP_QUERY, '0, '0, '0, 5'd0);
    send(OP_ACT, '0, '0, 10'd1, '0);
    send(OP_DEACT, '0, '0, 10'd1, '0);
    send(OP_DEACT, '0, '0, 10'd1, '0);
    send(OP_ACT, '0, '0, 10'd1023, '0);
    send(OP_DEACT, '0, '0, 10'd0, '0);
    send(OP_DEACT, '0, '0, 10'd2, '0);
    send(OP_DEACT, '0, '0, 10'd3, '0);
    send(OP_QUERY, '0, '0, '0, 5'd16);
    send(OP_ACT, '0, '0, 10'd2, '0);
    send(OP_QUERY, '0, '0, '0, 5'd16);
    for (int n = 0; n < 188; n++) begin
      logic [1:0] op;
      calm = (n >= 60 && n < 100);
      op = 2'($urandom_range(3));
      if (n < 40) op = OP_LOAD;
      send(op, rand_coord(), rand_coord(),
           ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(board.loaded + 2)),
           5'($urandom_range(31)));
    end
    calm = 0;
    send(OP_LOAD, '0, '0, '0, '0);
    send(OP_QUERY, rand_coord(), rand_coord(), '0, 5'd16);
    send(OP_ACT, '0, '0, 10'd1023, '0);
    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb_k_nearest_active_points: PASS");
    end else begin
      $display("tb_k_nearest_active_points: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
